/* src/rmtfq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmtfq_pkg
// Shared types and constants of the rotate and move-to-front queue.
// ----------------------------------------------------------------------------
package rmtfq_pkg;

	localparam int MAX_IDS_DEF = 64;
	localparam int COUNT_RESET = 64;
	localparam int ID_W        = 7;

	typedef enum logic {
		CMD_SERVE   = 1'b0,
		CMD_PROMOTE = 1'b1
	} cmd_t;

	localparam logic STS_OK     = 1'b0;
	localparam logic STS_ABSENT = 1'b1;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SRV,
		S_WALK,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic reload;
		logic sweep;
		logic accept;
		logic walk;
		logic res_bad;
		logic res_srv;
		logic out_load;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic sweep_last;
		logic promote;
		logic tgt_bad;
		logic walk_hit;
	} sts_t;

endpackage

/* src/rmtfq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmtfq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rmtfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/rmtfq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmtfq_dp
// Datapath: circular order store with head pointer, walk carry, result and
// output registers.
// ----------------------------------------------------------------------------
module rmtfq_dp #(
	parameter int MAX_IDS = rmtfq_pkg::MAX_IDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rmtfq_pkg::ctl_t               ctl,
	output rmtfq_pkg::sts_t               sts,
	input  logic [rmtfq_pkg::ID_W-1:0]    cfg_wr_data,
	input  logic                          cmd,
	input  logic [rmtfq_pkg::ID_W-1:0]    target_id,
	output logic [rmtfq_pkg::ID_W-1:0]    served_id,
	output logic                          status
);
	import rmtfq_pkg::*;

	localparam int AW      = $clog2(MAX_IDS);
	localparam int CW      = $clog2(MAX_IDS + 1);
	localparam int CNT_RST = (COUNT_RESET > MAX_IDS) ? MAX_IDS : COUNT_RESET;

	logic [CW-1:0]   count_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   raddr_q;
	logic [ID_W-1:0] carry_q;
	logic [ID_W-1:0] target_q;
	logic [ID_W-1:0] res_id_q;
	logic            res_st_q;
	logic [CW-1:0]   count_new;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [ID_W-1:0] ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [ID_W-1:0] ram_rdata;

	// next slot in the circular order of count_q entries
	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a,
		input logic [CW-1:0] cnt);
		logic [AW-1:0] r;
		if ((CW'(a) + CW'(1)) == cnt) begin
			r = '0;
		end else begin
			r = a + AW'(1);
		end
		return r;
	endfunction

	// clamp written count to 1..MAX_IDS
	always_comb begin
		if (cfg_wr_data == '0) begin
			count_new = CW'(1);
		end else if (int'(cfg_wr_data) > MAX_IDS) begin
			count_new = CW'(MAX_IDS);
		end else begin
			count_new = CW'(cfg_wr_data);
		end
	end

	always_comb begin
		sts.sweep_last = (CW'(ptr_q) + CW'(1)) == count_q;
		sts.promote    = (cmd == CMD_PROMOTE);
		sts.tgt_bad    = (target_id == '0) || (int'(target_id) > int'(count_q));
		sts.walk_hit   = (ram_rdata == target_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(CNT_RST);
			head_q  <= '0;
			ptr_q   <= '0;
		end else if (ctl.reload) begin
			count_q <= count_new;
			head_q  <= '0;
			ptr_q   <= '0;
		end else if (ctl.sweep) begin
			ptr_q <= sts.sweep_last ? '0 : ptr_q + AW'(1);
		end else if (ctl.res_srv) begin
			// front moves to the back: just advance the head
			head_q <= slot_inc(head_q, count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			raddr_q  <= head_q;
			carry_q  <= target_id;
			target_q <= target_id;
		end else if (ctl.walk && !sts.walk_hit) begin
			raddr_q <= slot_inc(raddr_q, count_q);
			carry_q <= ram_rdata;
		end

		if (ctl.res_bad) begin
			res_id_q <= '0;
			res_st_q <= STS_ABSENT;
		end else if (ctl.res_srv) begin
			res_id_q <= ram_rdata;
			res_st_q <= STS_OK;
		end else if (ctl.walk && sts.walk_hit) begin
			res_id_q <= '0;
			res_st_q <= STS_OK;
		end

		if (ctl.out_load) begin
			served_id <= res_id_q;
			status    <= res_st_q;
		end
	end

	// walk: each slot takes the carried word, carry picks up the old one
	always_comb begin
		ram_we    = ctl.sweep || ctl.walk;
		ram_waddr = ctl.sweep ? ptr_q : raddr_q;
		ram_wdata = ctl.sweep ? (ID_W'(ptr_q) + ID_W'(1)) : carry_q;
		ram_re    = ctl.accept || (ctl.walk && !sts.walk_hit);
		ram_raddr = ctl.accept ? head_q : slot_inc(raddr_q, count_q);
	end

	rmtfq_ram #(
		.WIDTH (ID_W),
		.DEPTH (MAX_IDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

/* src/rmtfq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmtfq_ctrl
// Controller: init sweep, command sequencing and output word handshake.
// ----------------------------------------------------------------------------
module rmtfq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  rmtfq_pkg::sts_t sts,
	output rmtfq_pkg::ctl_t ctl
);
	import rmtfq_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ctl        = '0;
		ctl.reload = cfg_wr_en;
		state_nxt  = state_q;
		in_ready   = 1'b0;
		unique case (state_q)
			S_INIT: begin
				ctl.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = !cfg_wr_en;
				if (in_valid && !cfg_wr_en) begin
					ctl.accept = 1'b1;
					if (!sts.promote) begin
						state_nxt = S_SRV;
					end else if (sts.tgt_bad) begin
						ctl.res_bad = 1'b1;
						state_nxt   = S_DONE;
					end else begin
						state_nxt = S_WALK;
					end
				end
			end
			S_SRV: begin
				ctl.res_srv = 1'b1;
				state_nxt   = S_DONE;
			end
			S_WALK: begin
				ctl.walk = 1'b1;
				if (sts.walk_hit) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_INIT;
			end
		endcase
		// any count write restarts the ascending reload
		if (cfg_wr_en) begin
			state_nxt = S_INIT;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* src/rotate_and_move_to_front_queue_core.sv */
`timescale 1ns / 1ps
// Sequencing: a serve goes accept, S_SRV, S_DONE; a promote goes accept, S_WALK
//   (one slot read and one slot written per cycle up to the target), S_DONE; a
//   rejected promote goes accept, S_DONE. S_DONE waits while the output word is
//   held unaccepted, and no new command is accepted until the last is done.
// Reset and every count write: a reload sweep over the count slots (64 by default)
//   writes ascending ids; in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
// rotate_and_move_to_front_queue_core
// Rotate / move-to-front id queue: controller plus circular-buffer datapath.
// ----------------------------------------------------------------------------
module rotate_and_move_to_front_queue_core #(
	parameter int MAX_IDS = rmtfq_pkg::MAX_IDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [rmtfq_pkg::ID_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cmd,
	input  logic [rmtfq_pkg::ID_W-1:0] target_id,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rmtfq_pkg::ID_W-1:0] served_id,
	output logic                       status
);
	import rmtfq_pkg::*;

	ctl_t ctl;
	sts_t sts;

	rmtfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	rmtfq_dp #(
		.MAX_IDS (MAX_IDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.target_id   (target_id),
		.served_id   (served_id),
		.status      (status)
	);

	// no word accepted in the same cycle as a count write
	a_no_accept_on_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready && cfg_wr_en))
		else $error("input accepted during count write");

	// a count write always starts a reload sweep
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> !in_ready)
		else $error("input ready right after count write");

	// one command at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word accepted while busy");

	// sweep, accept, walk, res_srv and out_load are mutually exclusive
	a_ctl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.sweep, ctl.accept, ctl.walk, ctl.res_srv, ctl.out_load}))
		else $error("overlapping datapath commands");

endmodule

/* verif/rmtfq_order_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmtfq_order_checker
// Watches the command, result and count-write ports of the queue core. Keeps
// its own copy of the id order, works out the result of every accepted
// command word, and compares each result word, field by field, with the
// oldest one due.
// ----------------------------------------------------------------------------
module rmtfq_order_checker #(
	parameter int MAX_IDS = rmtfq_pkg::MAX_IDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [rmtfq_pkg::ID_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       cmd,
	input  logic [rmtfq_pkg::ID_W-1:0] target_id,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [rmtfq_pkg::ID_W-1:0] served_id,
	input  logic                       status,
	output int                         fail_count,
	output int                         pending
);
	import rmtfq_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0] served;
		logic            sts;
	} result_t;

	logic [ID_W-1:0] id_order [MAX_IDS];
	int              id_count;
	result_t         results_due [$];

	function automatic void load_ascending_order(input logic [ID_W-1:0] req);
		if (req == 0)
			id_count = 1;
		else if (req > MAX_IDS)
			id_count = MAX_IDS;
		else
			id_count = req;
		for (int i = 0; i < MAX_IDS; i++)
			id_order[i] = ID_W'(i + 1);
	endfunction

	// Applies one command to the order and returns the result word it gives.
	function automatic result_t serve_or_promote(input cmd_t c, input logic [ID_W-1:0] id);
		result_t         r;
		logic [ID_W-1:0] head;
		int              pos;
		if (c == CMD_SERVE) begin
			head = id_order[0];
			for (int i = 1; i < id_count; i++)
				id_order[i-1] = id_order[i];
			id_order[id_count-1] = head;
			r.served = head;
			r.sts    = STS_OK;
			return r;
		end
		r.served = '0;
		r.sts    = STS_ABSENT;
		if (id == 0 || id > id_count)
			return r;
		pos = -1;
		for (int i = 0; i < id_count; i++)
			if (pos < 0 && id_order[i] == id)
				pos = i;
		if (pos >= 0) begin
			// entries ahead of the hit slide back one place
			for (int k = pos; k > 0; k--)
				id_order[k] = id_order[k-1];
			id_order[0] = id;
			r.sts = STS_OK;
		end
		return r;
	endfunction

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			load_ascending_order(ID_W'(COUNT_RESET));
			results_due.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				load_ascending_order(cfg_wr_data);
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: result word with none due: served_id %0d status %0d",
						$time, served_id, status);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					if (served_id !== want.served) begin
						$display("%0t: served_id expected %0d actual %0d",
							$time, want.served, served_id);
						fail_count++;
					end
					if (status !== want.sts) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.sts, status);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				results_due.push_back(serve_or_promote(cmd_t'(cmd), target_id));
			pending <= results_due.size();
		end
	end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the rotate / move-to-front queue core: directed corner words,
// then random serve and promote words over a range of id counts, with sender
// gaps, receiver stalls and a long receiver hold-off. Checking is done by
// rmtfq_order_checker.
// ----------------------------------------------------------------------------
module tb;
	import rmtfq_pkg::*;

	localparam int PHASE_WORDS    = 250;
	localparam int RX_HOLD_CYCLES = 300;

	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            cfg_wr_en   = 1'b0;
	logic [ID_W-1:0] cfg_wr_data = '0;
	logic            in_valid    = 1'b0;
	logic            in_ready;
	logic            cmd         = 1'b0;
	logic [ID_W-1:0] target_id   = '0;
	logic            out_valid;
	logic            out_ready   = 1'b0;
	logic [ID_W-1:0] served_id;
	logic            status;
	int              fail_count;
	int              pending;

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int eff_count    = COUNT_RESET;
	bit hold_kick    = 1'b0;
	bit hold_seen;
	int hold_left;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rotate_and_move_to_front_queue_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.target_id  (target_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.served_id  (served_id),
		.status     (status)
	);

	rmtfq_order_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.target_id  (target_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.served_id  (served_id),
		.status     (status),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Result side: random stalls, plus a long hold-off whenever hold_kick flips.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= RX_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_word(input cmd_t c, input logic [ID_W-1:0] id);
		if (tx_idle_pct != 0)
			while ($urandom_range(99) < tx_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid  <= 1'b1;
		cmd       <= c;
		target_id <= id;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold the command side until every due result word is out and the core idles.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_count(input logic [ID_W-1:0] n);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (n == 0)
			eff_count = 1;
		else if (n > MAX_IDS_DEF)
			eff_count = MAX_IDS_DEF;
		else
			eff_count = n;
	endtask

	task automatic send_serve();
		send_word(CMD_SERVE, ID_W'($urandom_range(127)));
	endtask

	// Mostly valid ids; a tenth are zero or beyond the count.
	task automatic send_random_word();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45)
			send_serve();
		else if (roll < 90)
			send_word(CMD_PROMOTE, ID_W'($urandom_range(eff_count, 1)));
		else if ($urandom_range(3) == 0)
			send_word(CMD_PROMOTE, '0);
		else
			send_word(CMD_PROMOTE, ID_W'($urandom_range(127, eff_count + 1)));
	endtask

	initial begin
		logic [ID_W-1:0] cnt;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset count: serve, promote from the back, already at front, out of range
		send_serve();
		send_word(CMD_PROMOTE, 7'd1);
		send_word(CMD_PROMOTE, 7'd1);
		send_word(CMD_PROMOTE, 7'd64);
		send_word(CMD_PROMOTE, 7'd0);
		send_word(CMD_PROMOTE, 7'd65);
		send_word(CMD_PROMOTE, 7'd127);
		send_serve();
		send_serve();
		send_word(CMD_PROMOTE, 7'd32);
		send_serve();

		// zero count becomes a single id
		write_count(7'd0);
		send_serve();
		send_serve();
		send_word(CMD_PROMOTE, 7'd1);
		send_word(CMD_PROMOTE, 7'd2);
		send_word(CMD_PROMOTE, 7'd0);

		write_count(7'd2);
		send_word(CMD_PROMOTE, 7'd2);
		send_serve();
		send_serve();
		send_word(CMD_PROMOTE, 7'd1);
		send_word(CMD_PROMOTE, 7'd3);

		// oversize count saturates
		write_count(7'd127);
		send_serve();
		send_word(CMD_PROMOTE, 7'd64);
		send_word(CMD_PROMOTE, 7'd65);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: cnt = 7'd64;
				1: cnt = 7'd1;
				2: cnt = 7'd2;
				3: cnt = 7'd65;
				4: cnt = ID_W'($urandom_range(63, 3));
				5: cnt = 7'd0;
				6: cnt = 7'd127;
				default: cnt = ID_W'($urandom_range(64, 1));
			endcase
			write_count(cnt);
			case (p % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
				1: begin
					tx_idle_pct = 83;
					rx_stall_pct <= 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 83;
				end
				default: begin
					tx_idle_pct = 16;
					rx_stall_pct <= 16;
				end
			endcase
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// long output hold-off while commands keep coming
				if ((p == 0 || p == 6) && i == 100)
					hold_kick <= ~hold_kick;
				if (p == 1 && i == 125)
					drain_results();
				send_random_word();
			end
		end

		drain_results();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("rotate_and_move_to_front_queue_core test passed");
		else
			$display("rotate_and_move_to_front_queue_core test failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("rotate_and_move_to_front_queue_core test failed");
		$finish;
	end

endmodule
